### sv/laplace_relaxation_sweep_defines.svh
// Assertion macros used by the relaxation sweep top level.
`ifndef LAPLACE_RELAXATION_SWEEP_DEFINES_SVH
`define LAPLACE_RELAXATION_SWEEP_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every rising clock edge outside reset.
`define LRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lrs assertion failed");

// Condition that must never be true outside reset.
`define LRS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lrs forbidden condition seen");

`else

`define LRS_ASSERT(lbl, prop)
`define LRS_ASSERT_NEVER(lbl, cond)

`endif

`endif

### sv/lrs_pkg.sv
// Package with types and constants of the Laplace relaxation sweep block.
package lrs_pkg;

  // Sizes.
  localparam int MAX_DIM_DEF = 128;
  localparam int CELL_W      = 16;
  localparam int CNT_W       = 16;
  localparam int DIM_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Action codes of a request.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SWEEP = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;
  localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

  // Input request.
  typedef struct packed {
    logic [1:0]        action;
    logic [6:0]        row;
    logic [6:0]        col;
    logic [CELL_W-1:0] value;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [CNT_W-1:0]  sweeps_done;
  } rsp_t;

  // Completion report from the controller to the output stage.
  typedef struct packed {
    logic              valid;
    logic              sweep;
    logic [CELL_W-1:0] cell_value;
  } ctrl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SW_A,
    ST_SW_B,
    ST_SW_F
  } state_e;

endpackage

### sv/lrs_grid_mem.sv
// Grid memory: one write port and two registered read ports.
module lrs_grid_mem
  import lrs_pkg::*;
#(
  parameter int AW = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr0_i,
  input  logic [AW-1:0]     raddr1_i,
  output logic [CELL_W-1:0] rdata0_o,
  output logic [CELL_W-1:0] rdata1_o
);

  logic [CELL_W-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports, old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

### sv/lrs_ctrl.sv
// Controller: serves cell requests and sequences a relaxation sweep over the grid memory.
module lrs_ctrl
  import lrs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int IW      = $clog2(MAX_DIM),
  parameter int AW      = 2 * IW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_t              req_i,
  input  logic [DIM_W-1:0]  rows_used_i,
  input  logic [DIM_W-1:0]  cols_used_i,
  output logic              idle_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [CELL_W-1:0] mem_wdata_o,
  output logic [AW-1:0]     mem_raddr0_o,
  output logic [AW-1:0]     mem_raddr1_o,
  input  logic [CELL_W-1:0] mem_rdata0_i,
  input  logic [CELL_W-1:0] mem_rdata1_i,
  output ctrl_rsp_t         rsp_o
);

  state_e state_q, state_d;

  // Sweep position, pending write position and last interior indexes.
  logic [IW-1:0] r_q, c_q, pr_q, pc_q, lr_q, lc_q;
  logic [CELL_W-1:0] up_q, down_q, left_q;
  logic first_q, pend_q, fwd_q, in_store_q;

  logic [IW-1:0]      row_idx, col_idx;
  logic               in_store;
  logic [10:0]        nr, nc;
  logic               sweep_ok;
  logic               last_cell;
  logic [CELL_W+1:0]  sum;
  logic [CELL_W-1:0]  result;
  logic [CELL_W-1:0]  left_val;

  // Request address decode.
  assign row_idx  = IW'(req_i.row);
  assign col_idx  = IW'(req_i.col);
  assign in_store = (int'(req_i.row) < MAX_DIM) && (int'(req_i.col) < MAX_DIM);

  // Used region, clipped to the store.
  assign nr = (11'(rows_used_i) > 11'(MAX_DIM)) ? 11'(MAX_DIM) : 11'(rows_used_i);
  assign nc = (11'(cols_used_i) > 11'(MAX_DIM)) ? 11'(MAX_DIM) : 11'(cols_used_i);
  assign sweep_ok = (nr >= 11'd3) && (nc >= 11'd3);

  assign last_cell = (r_q == lr_q) && (c_q == lc_q);

  // Four-neighbor average; right and boundary-left arrive from the read ports.
  assign left_val = first_q ? mem_rdata1_i : left_q;
  assign sum = 18'(up_q) + 18'(down_q) + 18'(mem_rdata0_i) + 18'(left_val);
  assign result = sum[CELL_W+1:2];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && start_i) begin
        pend_q <= 1'b0;
      end else if (state_q == ST_SW_B) begin
        pend_q <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.action == ACT_READ) begin
            state_d = ST_READ;
          end else if (req_i.action == ACT_SWEEP && sweep_ok) begin
            state_d = ST_SW_A;
          end
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SW_A: state_d = ST_SW_B;
      ST_SW_B: state_d = last_cell ? ST_SW_F : ST_SW_A;
      ST_SW_F: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory control and completion report.
  always_comb begin
    idle_o       = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = {pr_q, pc_q};
    mem_wdata_o  = result;
    mem_raddr0_o = {row_idx, col_idx};
    mem_raddr1_o = {row_idx, col_idx};
    rsp_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          case (req_i.action)
            ACT_WRITE: begin
              mem_we_o    = in_store;
              mem_waddr_o = {row_idx, col_idx};
              mem_wdata_o = req_i.value;
              rsp_o.valid = 1'b1;
            end
            ACT_SWEEP: begin
              // A region without interior completes at once.
              rsp_o.valid = !sweep_ok;
              rsp_o.sweep = !sweep_ok;
            end
            ACT_READ: begin
              rsp_o.valid = 1'b0;
            end
            default: begin
              rsp_o.valid = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        rsp_o.valid      = 1'b1;
        rsp_o.cell_value = in_store_q ? mem_rdata0_i : '0;
      end
      ST_SW_A: begin
        mem_we_o     = pend_q;
        mem_raddr0_o = {r_q - IW'(1), c_q};
        mem_raddr1_o = {r_q + IW'(1), c_q};
      end
      ST_SW_B: begin
        mem_raddr0_o = {r_q, c_q + IW'(1)};
        mem_raddr1_o = {r_q, c_q - IW'(1)};
      end
      ST_SW_F: begin
        mem_we_o    = 1'b1;
        rsp_o.valid = 1'b1;
        rsp_o.sweep = 1'b1;
      end
      default: begin
        idle_o = 1'b0;
      end
    endcase
  end

  // Sweep datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        in_store_q <= in_store;
        r_q        <= IW'(1);
        c_q        <= IW'(1);
        lr_q       <= IW'(nr - 11'd2);
        lc_q       <= IW'(nc - 11'd2);
        fwd_q      <= 1'b0;
      end
      ST_SW_A: begin
        if (pend_q) begin
          left_q <= result;
        end
        // The up neighbor is being written in this same cycle on narrow grids.
        fwd_q <= pend_q && (pr_q == r_q - IW'(1)) && (pc_q == c_q);
      end
      ST_SW_B: begin
        up_q    <= fwd_q ? left_q : mem_rdata0_i;
        down_q  <= mem_rdata1_i;
        pr_q    <= r_q;
        pc_q    <= c_q;
        first_q <= (c_q == IW'(1));
        if (c_q != lc_q) begin
          c_q <= c_q + IW'(1);
        end else if (r_q != lr_q) begin
          r_q <= r_q + IW'(1);
          c_q <= IW'(1);
        end
      end
      default: begin
        fwd_q <= fwd_q;
      end
    endcase
  end

endmodule

### sv/laplace_relaxation_sweep.sv
// Top level of the Laplace relaxation sweep block.
// The block holds a MAX_DIM by MAX_DIM grid of unsigned Q8.8 potentials in one
// synchronous memory with one write and two read ports. A read request passes
// through the read state and the output register. A sweep request over a used
// region of R rows and C columns visits each interior cell in the states
// ST_SW_A and ST_SW_B: each interior cell needs three fresh neighbor reads (up,
// down, right), the left neighbor is the value just computed or, in the first
// interior column, a boundary read, and the two read ports of the grid memory
// serve these reads across both states. A region smaller than three in
// either direction completes a sweep at once. The grid has no reset and
// no clearing pass; every cell must be written before it is read or swept.
// One request is worked on at a time; a new request is taken as soon as the
// previous result has been taken or is being taken.
`include "laplace_relaxation_sweep_defines.svh"

module laplace_relaxation_sweep
  import lrs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;

  logic [DIM_W-1:0] rows_used_q, cols_used_q;
  logic [CNT_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_rsp_q, out_rsp_d;

  logic              ctrl_idle;
  ctrl_rsp_t         ctrl_rsp;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr0, mem_raddr1;
  logic [CELL_W-1:0] mem_wdata, mem_rdata0, mem_rdata1;
  logic              in_accept;

  // Request handshake.
  assign in_ready_o = ctrl_idle && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= DIM_RESET;
      cols_used_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_USED: rows_used_q <= cfg_wdata_i;
        REG_COLS_USED: cols_used_q <= cfg_wdata_i;
        default: rows_used_q <= rows_used_q;
      endcase
    end
  end

  // Saturating count of completed sweeps.
  assign sweep_cnt_d = (ctrl_rsp.sweep && sweep_cnt_q != CNT_MAX) ?
                       sweep_cnt_q + CNT_W'(1) : sweep_cnt_q;

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (ctrl_rsp.valid) begin
      out_valid_d           = 1'b1;
      out_rsp_d.cell_value  = ctrl_rsp.cell_value;
      out_rsp_d.sweeps_done = sweep_cnt_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sweep_cnt_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Sequencer.
  lrs_ctrl #(
    .MAX_DIM(MAX_DIM),
    .IW     (IW),
    .AW     (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .req_i       (in_req_i),
    .rows_used_i (rows_used_q),
    .cols_used_i (cols_used_q),
    .idle_o      (ctrl_idle),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr0_o(mem_raddr0),
    .mem_raddr1_o(mem_raddr1),
    .mem_rdata0_i(mem_rdata0),
    .mem_rdata1_i(mem_rdata1),
    .rsp_o       (ctrl_rsp)
  );

  // Grid storage.
  lrs_grid_mem #(
    .AW(AW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr0_i(mem_raddr0),
    .raddr1_i(mem_raddr1),
    .rdata0_o(mem_rdata0),
    .rdata1_o(mem_rdata1)
  );

  // A finished result never lands on one that is still waiting.
  `LRS_ASSERT(a_no_overwrite, ctrl_rsp.valid |-> (!out_valid_q || out_ready_i))
  // A read request delivers its result through the read state and the output register.
  `LRS_ASSERT(a_read_latency, in_accept && in_req_i.action == ACT_READ |=> ##1 out_valid_q)
  // The sweep count moves only when a sweep completes.
  `LRS_ASSERT(a_cnt_moves, sweep_cnt_q != $past(sweep_cnt_q) |-> $past(ctrl_rsp.sweep))
  // No request is taken while the controller is busy.
  `LRS_ASSERT_NEVER(a_busy_accept, !ctrl_idle && in_accept)

endmodule

### tb/tb_laplace_relaxation_sweep.sv
// Self-checking testbench for the Laplace relaxation sweep block.
module tb_laplace_relaxation_sweep;
  timeunit 1ns;
  timeprecision 1ps;

  import lrs_pkg::*;

  localparam int GRID_DIM = MAX_DIM_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Mirror of the block: grid contents, sizes and count.
  logic [CELL_W-1:0] grid_model [GRID_DIM][GRID_DIM];
  int rows_model = GRID_DIM;
  int cols_model = GRID_DIM;
  logic [CNT_W-1:0] sweep_count_model = '0;
  rsp_t expected_rsp_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt = 0;
  int n_sent = 0;
  int n_sweeps = 0;
  int n_reads = 0;
  int n_checked = 0;

  laplace_relaxation_sweep uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Sizes above the store act as the full store.
  function automatic int used_dim(int d);
    return (d > GRID_DIM) ? GRID_DIM : d;
  endfunction

  // One in-place Gauss-Seidel pass over the interior of the used region, plus a saturating sweep count step.
  function automatic void relax_grid();
    int nr;
    int nc;
    logic [17:0] sum;
    nr = used_dim(rows_model);
    nc = used_dim(cols_model);
    if (nr >= 3 && nc >= 3) begin
      for (int r = 1; r + 1 < nr; r++) begin
        for (int c = 1; c + 1 < nc; c++) begin
          sum = {2'b00, grid_model[r-1][c]} + {2'b00, grid_model[r+1][c]}
              + {2'b00, grid_model[r][c-1]} + {2'b00, grid_model[r][c+1]};
          grid_model[r][c] = sum[17:2];
        end
      end
    end
    if (sweep_count_model != CNT_MAX) begin
      sweep_count_model++;
    end
  endfunction

  // Apply one request to the mirror and return the result it must produce.
  function automatic rsp_t apply_request(req_t rq);
    rsp_t rs;
    rs = '0;
    case (rq.action)
      ACT_WRITE: begin
        grid_model[rq.row][rq.col] = rq.value;
      end
      ACT_SWEEP: begin
        relax_grid();
      end
      ACT_READ: begin
        rs.cell_value = grid_model[rq.row][rq.col];
      end
      default: ;
    endcase
    rs.sweeps_done = sweep_count_model;
    return rs;
  endfunction

  // Present one request, hold it until accepted, then record its result.
  task automatic send_req(req_t rq);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp_q.push_back(apply_request(rq));
    n_sent++;
    if (rq.action == ACT_SWEEP) n_sweeps++;
    if (rq.action == ACT_READ) n_reads++;
  endtask

  task automatic write_cell(int r, int c, logic [CELL_W-1:0] v);
    req_t rq;
    rq.action = ACT_WRITE;
    rq.row = r[6:0];
    rq.col = c[6:0];
    rq.value = v;
    send_req(rq);
  endtask

  task automatic read_cell(int r, int c);
    req_t rq;
    rq.action = ACT_READ;
    rq.row = r[6:0];
    rq.col = c[6:0];
    rq.value = CELL_W'($urandom_range(0, 65535));
    send_req(rq);
  endtask

  // Sweeps and the unused action ignore the address and value fields.
  task automatic send_op(logic [1:0] op);
    req_t rq;
    rq.action = op;
    rq.row = 7'($urandom_range(0, 127));
    rq.col = 7'($urandom_range(0, 127));
    rq.value = CELL_W'($urandom_range(0, 65535));
    send_req(rq);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Program both region sizes while the block is idle.
  task automatic set_size(logic [7:0] rows, logic [7:0] cols);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ROWS_USED;
    cfg_wdata_i <= rows;
    @(negedge clk_i);
    cfg_idx_i <= REG_COLS_USED;
    cfg_wdata_i <= cols;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rows_model = int'(rows);
    cols_model = int'(cols);
  endtask

  // Load every cell of the used region so that sweeps only touch written data.
  task automatic fill_region();
    for (int r = 0; r < used_dim(rows_model); r++) begin
      for (int c = 0; c < used_dim(cols_model); c++) begin
        write_cell(r, c, CELL_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  // Smallest region, extreme values, every action and the store corners.
  task automatic test_directed_cells();
    set_size(8'd3, 8'd3);
    write_cell(0, 0, 16'h0000);
    write_cell(0, 1, 16'hFFFF);
    write_cell(0, 2, 16'h8000);
    write_cell(1, 0, 16'hFFFF);
    write_cell(1, 1, 16'h1234);
    write_cell(1, 2, 16'hFFFF);
    write_cell(2, 0, 16'h0001);
    write_cell(2, 1, 16'hFFFF);
    write_cell(2, 2, 16'h7FFF);
    read_cell(1, 1);
    // All four neighbors at full scale keep the center at full scale.
    send_op(ACT_SWEEP);
    read_cell(1, 1);
    read_cell(0, 2);
    // One neighbor at zero shows the truncating divide.
    write_cell(0, 1, 16'h0000);
    send_op(ACT_SWEEP);
    read_cell(1, 1);
    write_cell(127, 127, 16'hFFFF);
    write_cell(127, 0, 16'hA5A5);
    write_cell(0, 127, 16'h5A5A);
    read_cell(127, 127);
    read_cell(127, 0);
    read_cell(0, 127);
    send_op(ACT_UNUSED);
  endtask

  // Regions without interior still count a sweep and change nothing.
  task automatic test_degenerate_regions();
    set_size(8'd2, 8'd5);
    send_op(ACT_SWEEP);
    set_size(8'd0, 8'd0);
    send_op(ACT_SWEEP);
    set_size(8'd5, 8'd1);
    send_op(ACT_SWEEP);
    read_cell(1, 1);
    read_cell(0, 0);
  endtask

  // Sizes above the store in one direction, too thin in the other.
  task automatic test_oversize_regions();
    set_size(8'd255, 8'd2);
    send_op(ACT_SWEEP);
    set_size(8'd2, 8'd200);
    send_op(ACT_SWEEP);
    read_cell(127, 127);
    read_cell(0, 127);
  endtask

  // Mixed traffic over a small random region.
  task automatic test_random_traffic(int n_items);
    int pick;
    int r;
    int c;
    set_size(8'($urandom_range(3, 4)), 8'($urandom_range(3, 4)));
    fill_region();
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, used_dim(rows_model) - 1);
      c = $urandom_range(0, used_dim(cols_model) - 1);
      if (pick < 35) begin
        write_cell(r, c, CELL_W'($urandom_range(0, 65535)));
      end else if (pick < 45) begin
        write_cell($urandom_range(0, 127), $urandom_range(0, 127),
                   CELL_W'($urandom_range(0, 65535)));
      end else if (pick < 75) begin
        read_cell(r, c);
      end else if (pick < 95) begin
        send_op(ACT_SWEEP);
      end else begin
        send_op(ACT_UNUSED);
      end
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result cell_value=%h sweeps_done=%h",
                 $time, out_rsp_o.cell_value, out_rsp_o.sweeps_done);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        n_checked++;
        if (out_rsp_o.cell_value !== exp_rsp.cell_value) begin
          err_cnt++;
          $display("%0t: cell_value expected %h actual %h",
                   $time, exp_rsp.cell_value, out_rsp_o.cell_value);
        end
        if (out_rsp_o.sweeps_done !== exp_rsp.sweeps_done) begin
          err_cnt++;
          $display("%0t: sweeps_done expected %h actual %h",
                   $time, exp_rsp.sweeps_done, out_rsp_o.sweeps_done);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int drain_cycles;
    drain_cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 52;
    test_directed_cells();
    test_degenerate_regions();
    test_random_traffic(12);

    send_idle_pct = 52;
    recv_idle_pct = 31;
    test_oversize_regions();
    test_random_traffic(12);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(12);

    // Drain outstanding results, then let the pipeline go quiet.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (expected_rsp_q.size() != 0) begin
      err_cnt += expected_rsp_q.size();
      $display("%0t: %0d results never arrived", $time, expected_rsp_q.size());
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d sweeps, %0d reads) over three idle mixes,",
             n_sent, n_sweeps, n_reads);
    $display("small, empty and oversize regions; %0d results compared.",
             n_checked);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #40_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/lrs_pkg.sv
sv/lrs_grid_mem.sv
sv/lrs_ctrl.sv
sv/laplace_relaxation_sweep.sv
tb/tb_laplace_relaxation_sweep.sv
